// ----- rtl/cll_pkg.sv -----
// ----------------------------------------------------------------------------
// cll_pkg
// Shared sizes, codes and helpers for the circular list with cursor.
// ----------------------------------------------------------------------------
package cll_pkg;

    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMD_W   = 3;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    typedef logic [PAYLOAD_WIDTH-1:0] word_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_FWD    = 3'd2,
        CMD_BACK   = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INS2,
        S_FETCH
    } state_t;

    // Bus word to stored word: keep the low bits, zero fill above.
    function automatic word_t to_word(input logic [WORD_W-1:0] x);
        word_t w;
        w = '0;
        for (int i = 0; i < PAYLOAD_WIDTH && i < WORD_W; i++)
        begin
            w[i] = x[i];
        end
        return w;
    endfunction

    // Stored word to bus word.
    function automatic logic [WORD_W-1:0] to_bus(input word_t w);
        logic [WORD_W-1:0] x;
        x = '0;
        for (int i = 0; i < PAYLOAD_WIDTH && i < WORD_W; i++)
        begin
            x[i] = w[i];
        end
        return x;
    endfunction

    function automatic logic [COUNT_W-1:0] to_count(input cnt_t c);
        logic [COUNT_W-1:0] x;
        x = '0;
        for (int i = 0; i < CNT_W && i < COUNT_W; i++)
        begin
            x[i] = c[i];
        end
        return x;
    endfunction

endpackage

// ----- rtl/cll_ram.sv -----
// ----------------------------------------------------------------------------
// cll_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/circular_list_with_cursor.sv -----
// ----------------------------------------------------------------------------
// circular_list_with_cursor
// Bounded doubly linked ring of payload words with a cursor.
// ----------------------------------------------------------------------------
// Each command transfer yields exactly one result transfer. Step back, step
// forward and delete of a non-last entry go from S_EXEC on to S_FETCH, as
// insert into a ring that is neither empty nor full goes on to S_INS2; all
// other commands form their result in S_EXEC.
// The payload and link stores are RAMs with one write port and a registered
// read: the entry at the cursor is read in S_IDLE, S_EXEC writes links back,
// and then S_INS2 writes the second pair of links of an insert or S_FETCH
// takes the word at the new cursor. A new command is taken in the cycle after
// a result is formed, even while that result still waits in the output
// register; a result that cannot leave holds the sequence.
module circular_list_with_cursor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command[2:0], payload_in[34:3], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // payload_out[31:0], entry_count[36:32],
                                   // status[38:37], zero fill
);

    import cll_pkg::*;

    state_t             state_reg, state_next;
    idx_t               cur_reg, cur_next;
    cnt_t               occ_reg, occ_next;
    logic [CAPACITY-1:0] used_reg, used_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    word_t              word_reg, word_next;
    idx_t               ins_succ_reg, ins_succ_next;
    idx_t               ins_pred_reg, ins_pred_next;

    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_payload_reg, out_payload_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    status_t            out_status_reg, out_status_next;

    logic               fwd_we, back_we, pay_we;
    idx_t               fwd_waddr, back_waddr, pay_waddr, pay_raddr;
    idx_t               fwd_wdata, back_wdata;
    idx_t               fwd_rdata, back_rdata;
    word_t              pay_rdata;

    idx_t               free_slot;
    logic               out_free;
    logic               load_out;
    logic [WORD_W-1:0]  res_payload;
    status_t            res_status;

    cll_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(CAPACITY)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (word_reg),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    cll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (cur_reg),
        .rdata (fwd_rdata)
    );

    cll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr (cur_reg),
        .rdata (back_rdata)
    );

    // Lowest-numbered free slot.
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = idx_t'(i);
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_count_reg, out_payload_reg};

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        occ_next      = occ_reg;
        used_next     = used_reg;
        cmd_next      = cmd_reg;
        word_next     = word_reg;
        ins_succ_next = ins_succ_reg;
        ins_pred_next = ins_pred_reg;

        fwd_we     = 1'b0;
        fwd_waddr  = cur_reg;
        fwd_wdata  = '0;
        back_we    = 1'b0;
        back_waddr = cur_reg;
        back_wdata = '0;
        pay_we     = 1'b0;
        pay_waddr  = free_slot;
        pay_raddr  = cur_reg;

        load_out    = 1'b0;
        res_payload = '0;
        res_status  = STAT_DONE;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tdata[2:0];
                    word_next  = to_word(s_tdata[34:3]);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (occ_reg == cnt_t'(CAPACITY))
                    begin
                        if (out_free)
                        begin
                            load_out    = 1'b1;
                            res_payload = to_bus(pay_rdata);
                            res_status  = STAT_FULL;
                            state_next  = S_IDLE;
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        if (out_free)
                        begin
                            // First entry links to itself.
                            fwd_we                = 1'b1;
                            fwd_waddr             = free_slot;
                            fwd_wdata             = free_slot;
                            back_we               = 1'b1;
                            back_waddr            = free_slot;
                            back_wdata            = free_slot;
                            pay_we                = 1'b1;
                            used_next[free_slot]  = 1'b1;
                            cur_next              = free_slot;
                            occ_next              = occ_reg + cnt_t'(1);
                            load_out              = 1'b1;
                            res_payload           = to_bus(word_reg);
                            state_next            = S_IDLE;
                        end
                    end
                    else
                    begin
                        // Splice in: cursor and old successor now, new slot next.
                        fwd_we               = 1'b1;
                        fwd_waddr            = cur_reg;
                        fwd_wdata            = free_slot;
                        back_we              = 1'b1;
                        back_waddr           = fwd_rdata;
                        back_wdata           = free_slot;
                        pay_we               = 1'b1;
                        used_next[free_slot] = 1'b1;
                        ins_succ_next        = fwd_rdata;
                        ins_pred_next        = cur_reg;
                        cur_next             = free_slot;
                        occ_next             = occ_reg + cnt_t'(1);
                        state_next           = S_INS2;
                    end
                end
                else if (occ_reg == '0)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        res_status = STAT_EMPTY;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    case (cmd_reg)
                        CMD_DELETE:
                        begin
                            if (occ_reg == cnt_t'(1))
                            begin
                                if (out_free)
                                begin
                                    used_next[cur_reg] = 1'b0;
                                    cur_next           = '0;
                                    occ_next           = '0;
                                    load_out           = 1'b1;
                                    state_next         = S_IDLE;
                                end
                            end
                            else
                            begin
                                // Unlink; fetch the successor's word.
                                fwd_we             = 1'b1;
                                fwd_waddr          = back_rdata;
                                fwd_wdata          = fwd_rdata;
                                back_we            = 1'b1;
                                back_waddr         = fwd_rdata;
                                back_wdata         = back_rdata;
                                used_next[cur_reg] = 1'b0;
                                cur_next           = fwd_rdata;
                                occ_next           = occ_reg - cnt_t'(1);
                                pay_raddr          = fwd_rdata;
                                state_next         = S_FETCH;
                            end
                        end
                        CMD_FWD:
                        begin
                            cur_next   = fwd_rdata;
                            pay_raddr  = fwd_rdata;
                            state_next = S_FETCH;
                        end
                        CMD_BACK:
                        begin
                            cur_next   = back_rdata;
                            pay_raddr  = back_rdata;
                            state_next = S_FETCH;
                        end
                        CMD_READ:
                        begin
                            if (out_free)
                            begin
                                cur_next    = fwd_rdata;
                                load_out    = 1'b1;
                                res_payload = to_bus(pay_rdata);
                                state_next  = S_IDLE;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                load_out    = 1'b1;
                                res_payload = to_bus(pay_rdata);
                                state_next  = S_IDLE;
                            end
                        end
                    endcase
                end
            end

            S_INS2:
            begin
                if (out_free)
                begin
                    fwd_we      = 1'b1;
                    fwd_waddr   = cur_reg;
                    fwd_wdata   = ins_succ_reg;
                    back_we     = 1'b1;
                    back_waddr  = cur_reg;
                    back_wdata  = ins_pred_reg;
                    load_out    = 1'b1;
                    res_payload = to_bus(word_reg);
                    state_next  = S_IDLE;
                end
            end

            S_FETCH:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    res_payload = to_bus(pay_rdata);
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output register: load a new result or drop the one taken.
        out_valid_next   = out_valid_reg && !m_tready;
        out_payload_next = out_payload_reg;
        out_count_next   = out_count_reg;
        out_status_next  = out_status_reg;
        if (load_out)
        begin
            out_valid_next   = 1'b1;
            out_payload_next = res_payload;
            out_count_next   = to_count(occ_next);
            out_status_next  = res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            occ_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            occ_reg       <= occ_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        word_reg        <= word_next;
        ins_succ_reg    <= ins_succ_next;
        ins_pred_reg    <= ins_pred_next;
        out_payload_reg <= out_payload_next;
        out_count_reg   <= out_count_next;
        out_status_reg  <= out_status_next;
    end

endmodule
